>>> design/hsvrgb_pkg.sv
// hsvrgb_pkg: shared types and constants for the hsv to inverted rgb duty converter
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

  localparam int FRAC_BITS_DEF = 10;

  localparam int HUE_W  = 16;
  localparam int SAT_W  = 12;
  localparam int DUTY_W = 11;
  localparam int REM_W  = 12;

  // hue in 1/64 degree: full circle and one 60 degree sector
  localparam int HUE_FULL   = 23040;
  localparam int HUE_SECTOR = 3840;
  localparam int NUM_SECTOR = 6;

  // 3840 = 15 << 8
  localparam int SECTOR_SHIFT = 8;
  localparam int SECTOR_DIV   = 15;

  typedef enum logic [2:0] {
    SEC_R_Y  = 3'd0,
    SEC_Y_G  = 3'd1,
    SEC_G_C  = 3'd2,
    SEC_C_B  = 3'd3,
    SEC_B_M  = 3'd4,
    SEC_M_R  = 3'd5,
    SEC_WRAP = 3'd6
  } sector_t;

  typedef struct packed {
    logic        [HUE_W-1:0] hue;
    logic signed [SAT_W-1:0] saturation;
    logic signed [SAT_W-1:0] brightness;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;
  } out_beat_t;

endpackage

`default_nettype wire

>>> design/hsvrgb_in_if.sv
// hsvrgb_in_if: valid/ready channel carrying one hsv triple per beat
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_in_if;
  logic                 valid;
  logic                 ready;
  hsvrgb_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/hsvrgb_out_if.sv
// hsvrgb_out_if: valid/ready channel carrying three duty values per beat
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_out_if;
  logic                  valid;
  logic                  ready;
  hsvrgb_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/hsvrgb_hue_decode.sv
// hsvrgb_hue_decode: hue wrap, 60 degree sector and remainder within the sector
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_hue_decode (
  input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
  output hsvrgb_pkg::sector_t          sector,
  output logic [hsvrgb_pkg::REM_W-1:0] rem
);

  logic [hsvrgb_pkg::HUE_W-1:0] hue_w;
  logic [hsvrgb_pkg::HUE_W-1:0] base;
  logic [2:0]                   cnt;

  always_comb begin
    if (hue > hsvrgb_pkg::HUE_W'(hsvrgb_pkg::HUE_FULL)) begin
      hue_w = '0;
    end else begin
      hue_w = hue;
    end
    cnt  = '0;
    base = '0;
    // thermometer of sector boundaries
    for (int k = 1; k <= hsvrgb_pkg::NUM_SECTOR; k++) begin
      if (hue_w >= hsvrgb_pkg::HUE_W'(k * hsvrgb_pkg::HUE_SECTOR)) begin
        cnt  = cnt + 3'd1;
        base = hsvrgb_pkg::HUE_W'(k * hsvrgb_pkg::HUE_SECTOR);
      end
    end
    sector = hsvrgb_pkg::sector_t'(cnt);
    rem    = hsvrgb_pkg::REM_W'(hue_w - base);
  end

endmodule

`default_nettype wire

>>> design/hsv_to_rgb_inverted_duty_top.sv
// hsv_to_rgb_inverted_duty_top: pipelined hsv to inverted rgb pwm duty converter
//
//   channel  modport  beat contents
//   hsv      sink     hue, saturation, brightness
//   rgb      source   red_duty, green_duty, blue_duty
//
// six register stages; one beat enters per cycle while rgb does not stall
// stages: hue decode and clamp, fraction estimate, fraction fixup,
//   saturation products, value products, channel select
// each stage loads when empty or when the next one moves, so bubbles collapse
// a stall on rgb holds the pipeline in place; rst clears only the valid bits
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_inverted_duty_top #(
  parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  hsvrgb_in_if.sink     hsv,
  hsvrgb_out_if.source  rgb
);

  localparam int W      = FRAC_BITS + 1;
  localparam int MW     = hsvrgb_pkg::SAT_W - 1;
  localparam int CW     = (W > MW) ? W : MW;
  localparam int XW     = FRAC_BITS + 4;
  localparam int SH     = FRAC_BITS + 8;
  localparam int RW     = SH - 3;
  localparam int SHL    = (FRAC_BITS >= hsvrgb_pkg::SECTOR_SHIFT) ?
                          FRAC_BITS - hsvrgb_pkg::SECTOR_SHIFT : 0;
  localparam int SHR    = (FRAC_BITS >= hsvrgb_pkg::SECTOR_SHIFT) ?
                          0 : hsvrgb_pkg::SECTOR_SHIFT - FRAC_BITS;
  localparam int NST    = 6;
  localparam int DutyW  = hsvrgb_pkg::DUTY_W;
  localparam int RemW   = hsvrgb_pkg::REM_W;
  localparam int Div    = hsvrgb_pkg::SECTOR_DIV;

  localparam logic [W-1:0]  ONE   = W'(1) << FRAC_BITS;
  localparam logic [RW-1:0] RECIP = RW'((longint'(1) << SH) / Div);

  // pipeline control
  logic [NST-1:0] vld;
  logic [NST-1:0] ld;

  always_comb begin
    ld[NST-1] = !vld[NST-1] || rgb.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= hsv.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign hsv.ready = ld[0];
  assign rgb.valid = vld[NST-1];

  // stage 1: clamp and hue decode
  hsvrgb_pkg::sector_t sec_in;
  logic [RemW-1:0]     rem_in;
  logic [W-1:0]        sat_c;
  logic [W-1:0]        val_c;

  hsvrgb_hue_decode u_hue_decode (
    .hue    (hsv.data.hue),
    .sector (sec_in),
    .rem    (rem_in)
  );

  always_comb begin
    if (hsv.data.saturation[MW]) begin
      sat_c = '0;
    end else if (CW'(hsv.data.saturation[MW-1:0]) > CW'(ONE)) begin
      sat_c = ONE;
    end else begin
      sat_c = W'(hsv.data.saturation[MW-1:0]);
    end
    if (hsv.data.brightness[MW]) begin
      val_c = '0;
    end else if (CW'(hsv.data.brightness[MW-1:0]) > CW'(ONE)) begin
      val_c = ONE;
    end else begin
      val_c = W'(hsv.data.brightness[MW-1:0]);
    end
  end

  logic [W-1:0]        s1_sat;
  logic [W-1:0]        s1_val;
  logic                s1_grey;
  hsvrgb_pkg::sector_t s1_sector;
  logic [RemW-1:0]     s1_rem;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_sat    <= sat_c;
      s1_val    <= val_c;
      s1_grey   <= (sat_c == '0);
      s1_sector <= sec_in;
      s1_rem    <= rem_in;
    end
  end

  // stage 2: fraction estimate by reciprocal, p product
  logic [XW-1:0]      x1;
  logic [XW+RW-1:0]   est_prod;
  logic [2*W-1:0]     p_prod;

  always_comb begin
    if (FRAC_BITS >= hsvrgb_pkg::SECTOR_SHIFT) begin
      x1 = XW'((RemW+SHL)'(s1_rem) << SHL);
    end else begin
      x1 = XW'(s1_rem >> SHR);
    end
    est_prod = (XW+RW)'(x1) * (XW+RW)'(RECIP);
    p_prod   = (2*W)'(s1_val) * (2*W)'(ONE - s1_sat);
  end

  logic [W-1:0]         s2_sat;
  logic [W-1:0]         s2_val;
  logic                 s2_grey;
  hsvrgb_pkg::sector_t  s2_sector;
  logic [XW-1:0]        s2_x;
  logic [FRAC_BITS-1:0] s2_q0;
  logic [W-1:0]         s2_p;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_sat    <= s1_sat;
      s2_val    <= s1_val;
      s2_grey   <= s1_grey;
      s2_sector <= s1_sector;
      s2_x      <= x1;
      s2_q0     <= est_prod[SH +: FRAC_BITS];
      s2_p      <= p_prod[FRAC_BITS +: W];
    end
  end

  // stage 3: estimate is at most one low
  logic [XW-1:0]        q15;
  logic [XW-1:0]        resid;
  logic [FRAC_BITS-1:0] frac;

  always_comb begin
    q15   = (XW'(s2_q0) << 4) - XW'(s2_q0);
    resid = s2_x - q15;
    frac  = (resid >= XW'(Div)) ? s2_q0 + FRAC_BITS'(1) : s2_q0;
  end

  logic [W-1:0]         s3_sat;
  logic [W-1:0]         s3_val;
  logic                 s3_grey;
  hsvrgb_pkg::sector_t  s3_sector;
  logic [FRAC_BITS-1:0] s3_frac;
  logic [W-1:0]         s3_p;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_sat    <= s2_sat;
      s3_val    <= s2_val;
      s3_grey   <= s2_grey;
      s3_sector <= s2_sector;
      s3_frac   <= frac;
      s3_p      <= s2_p;
    end
  end

  // stage 4: s*f and s*(1-f)
  logic [W+FRAC_BITS-1:0] sf_prod;
  logic [2*W-1:0]         snf_prod;

  always_comb begin
    sf_prod  = (W+FRAC_BITS)'(s3_sat) * (W+FRAC_BITS)'(s3_frac);
    snf_prod = (2*W)'(s3_sat) * (2*W)'(ONE - W'(s3_frac));
  end

  logic [W-1:0]        s4_val;
  logic                s4_grey;
  hsvrgb_pkg::sector_t s4_sector;
  logic [W-1:0]        s4_p;
  logic [W-1:0]        s4_sf;
  logic [W-1:0]        s4_snf;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_val    <= s3_val;
      s4_grey   <= s3_grey;
      s4_sector <= s3_sector;
      s4_p      <= s3_p;
      s4_sf     <= sf_prod[FRAC_BITS +: W];
      s4_snf    <= snf_prod[FRAC_BITS +: W];
    end
  end

  // stage 5: q and t
  logic [2*W-1:0] q_prod;
  logic [2*W-1:0] t_prod;

  always_comb begin
    q_prod = (2*W)'(s4_val) * (2*W)'(ONE - s4_sf);
    t_prod = (2*W)'(s4_val) * (2*W)'(ONE - s4_snf);
  end

  logic [W-1:0]        s5_val;
  logic                s5_grey;
  hsvrgb_pkg::sector_t s5_sector;
  logic [W-1:0]        s5_p;
  logic [W-1:0]        s5_q;
  logic [W-1:0]        s5_t;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_val    <= s4_val;
      s5_grey   <= s4_grey;
      s5_sector <= s4_sector;
      s5_p      <= s4_p;
      s5_q      <= q_prod[FRAC_BITS +: W];
      s5_t      <= t_prod[FRAC_BITS +: W];
    end
  end

  // stage 6: channel select and inversion
  logic [W-1:0]          lvl_r;
  logic [W-1:0]          lvl_g;
  logic [W-1:0]          lvl_b;
  hsvrgb_pkg::out_beat_t duty;

  always_comb begin
    if (s5_grey) begin
      lvl_r = s5_val;
      lvl_g = s5_val;
      lvl_b = s5_val;
    end else begin
      case (s5_sector)
        hsvrgb_pkg::SEC_R_Y: begin
          lvl_r = s5_val; lvl_g = s5_t;   lvl_b = s5_p;
        end
        hsvrgb_pkg::SEC_Y_G: begin
          lvl_r = s5_q;   lvl_g = s5_val; lvl_b = s5_p;
        end
        hsvrgb_pkg::SEC_G_C: begin
          lvl_r = s5_p;   lvl_g = s5_val; lvl_b = s5_t;
        end
        hsvrgb_pkg::SEC_C_B: begin
          lvl_r = s5_p;   lvl_g = s5_q;   lvl_b = s5_val;
        end
        hsvrgb_pkg::SEC_B_M: begin
          lvl_r = s5_t;   lvl_g = s5_p;   lvl_b = s5_val;
        end
        default: begin
          lvl_r = s5_val; lvl_g = s5_p;   lvl_b = s5_q;
        end
      endcase
    end
    duty.red_duty   = DutyW'(ONE - lvl_r);
    duty.green_duty = DutyW'(ONE - lvl_g);
    duty.blue_duty  = DutyW'(ONE - lvl_b);
  end

  hsvrgb_pkg::out_beat_t s6_duty;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_duty <= duty;
    end
  end

  assign rgb.data = s6_duty;

  // checks
  a_valid_clear: assert property (@(posedge clk) rst |=> !rgb.valid)
    else $error("output valid after reset");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !hsv.ready |-> (vld == '1))
    else $error("input stalled while pipeline has a bubble");

  a_frac_fix: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (resid < XW'(2 * Div)))
    else $error("fraction estimate off by more than one");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    rgb.valid |-> (FRAC_BITS > 10) ||
      (rgb.data.red_duty <= DutyW'(ONE) && rgb.data.green_duty <= DutyW'(ONE) &&
       rgb.data.blue_duty <= DutyW'(ONE)))
    else $error("duty above full scale");

endmodule

`default_nettype wire
